@@ hw/rtl/acp_pkg.sv @@
// Shared types, constants and the weight table of the alignment column profile block.
`default_nettype none

package acp_pkg;

   localparam int ROW_FIELD_W    = 10;
   localparam int COLUMN_FIELD_W = 16;
   localparam int MASK_W         = 4;
   localparam int PTS_W          = 4;
   localparam int WEIGHT_W       = 14;
   localparam int COUNT_W        = 11;
   localparam int UNIT_WEIGHT    = 12;

   localparam int DEFAULT_MAX_ROWS    = 1024;
   localparam int DEFAULT_COLUMN_BITS = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_FIELD_W = COLUMN_FIELD_W + 6 * WEIGHT_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [WEIGHT_W-1:0] SUM_MAX = {WEIGHT_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_SKIP = 2'd0,
      KIND_BASE = 2'd1,
      KIND_GAP  = 2'd2
   } cell_kind_type;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0]    row;
      logic [COLUMN_FIELD_W-1:0] column;
      cell_kind_type             kind;
      logic [MASK_W-1:0]         mask;
      logic [PTS_W-1:0]          pts;
      logic                      first;
      logic                      last;
   } cell_entry_type;

   typedef struct packed {
      logic [COLUMN_FIELD_W-1:0] column;
      logic [WEIGHT_W-1:0]       sum_a;
      logic [WEIGHT_W-1:0]       sum_g;
      logic [WEIGHT_W-1:0]       sum_c;
      logic [WEIGHT_W-1:0]       sum_t;
      logic [COUNT_W-1:0]        open_count;
      logic [COUNT_W-1:0]        extend_count;
   } profile_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clear_done;
      logic stage_valid;
      logic stage_last;
   } back_status_type;

   // 12 / popcount(mask), zero for an empty mask
   function automatic logic [PTS_W-1:0] weight_of_mask(input logic [MASK_W-1:0] mask);
      logic [PTS_W-1:0] pts;
      unique case (mask)
         4'h0:                      pts = 4'd0;
         4'h1, 4'h2, 4'h4, 4'h8:    pts = 4'd12;
         4'h3, 4'h5, 4'h6,
         4'h9, 4'hA, 4'hC:          pts = 4'd6;
         4'h7, 4'hB, 4'hD, 4'hE:    pts = 4'd4;
         4'hF:                      pts = 4'd3;
         default:                   pts = 4'd0;
      endcase
      return pts;
   endfunction

   // count * 12, saturated to the weight field
   function automatic logic [WEIGHT_W-1:0] gap_weight(input logic [COUNT_W-1:0] count);
      logic [WEIGHT_W+1:0] prod;
      prod = (WEIGHT_W+2)'({count, 3'b000}) + (WEIGHT_W+2)'({count, 2'b00});
      return (prod > (WEIGHT_W+2)'(SUM_MAX)) ? SUM_MAX : prod[WEIGHT_W-1:0];
   endfunction

   // saturating add of a base weight to a sum
   function automatic logic [WEIGHT_W-1:0] sat_add_sum(input logic [WEIGHT_W-1:0] sum,
                                                       input logic [PTS_W-1:0]    pts);
      logic [WEIGHT_W:0] total;
      total = {1'b0, sum} + (WEIGHT_W+1)'(pts);
      return total[WEIGHT_W] ? SUM_MAX : total[WEIGHT_W-1:0];
   endfunction

endpackage : acp_pkg

`default_nettype wire

@@ hw/rtl/acp_front.sv @@
// Front end: takes requests, folds the row into range and classifies each cell.
`default_nettype none

module acp_front
   import acp_pkg::*;
#(
   parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
   parameter int COLUMN_BITS = DEFAULT_COLUMN_BITS
) (
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                   req_tlast,
   input  wire queue_status_type       q_status,
   input  wire back_status_type        back_status,
   output logic                        push_valid,
   output cell_entry_type              push_entry
);

   localparam int COL_KEEP = (COLUMN_BITS < COLUMN_FIELD_W) ? COLUMN_BITS : COLUMN_FIELD_W;
   localparam logic [COLUMN_FIELD_W-1:0] COL_MASK =
      COLUMN_FIELD_W'((64'(1) << COL_KEEP) - 64'(1));
   localparam int MOD_W = ROW_FIELD_W + 18;

   logic [ROW_FIELD_W-1:0]    row_raw;
   logic [COLUMN_FIELD_W-1:0] column_raw;
   logic [MASK_W-1:0]         mask_raw;
   logic                      present;
   logic [MOD_W-1:0]          row_rem;
   logic [MOD_W-1:0]          step;

   assign row_raw    = req_tdata[ROW_FIELD_W-1:0];
   assign column_raw = req_tdata[ROW_FIELD_W +: COLUMN_FIELD_W];
   assign mask_raw   = req_tdata[ROW_FIELD_W + COLUMN_FIELD_W +: MASK_W];
   assign present    = req_tuser[0];

   // row modulo MAX_ROWS by restoring subtraction of shifted constants
   always_comb begin
      row_rem = MOD_W'(row_raw);
      step    = '0;
      for (int i = ROW_FIELD_W - 1; i >= 0; i--) begin
         step = MOD_W'(MAX_ROWS) << i;
         if (row_rem >= step) begin
            row_rem = row_rem - step;
         end
      end
   end

   assign req_tready = back_status.clear_done && !q_status.full;
   assign push_valid = req_tvalid && req_tready;

   always_comb begin
      push_entry.row    = row_rem[ROW_FIELD_W-1:0];
      push_entry.column = column_raw & COL_MASK;
      push_entry.mask   = mask_raw;
      push_entry.pts    = weight_of_mask(mask_raw);
      push_entry.first  = req_tuser[1];
      push_entry.last   = req_tlast;
      priority if (!present) begin
         push_entry.kind = KIND_GAP;
      end else if (mask_raw != '0) begin
         push_entry.kind = KIND_BASE;
      end else begin
         push_entry.kind = KIND_SKIP;
      end
   end

endmodule : acp_front

`default_nettype wire

@@ hw/rtl/acp_queue.sv @@
// Short queue of classified cells between the front and the back end.
`default_nettype none

module acp_queue
   import acp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   input  wire cell_entry_type push_entry,
   input  wire logic           pop,
   output cell_entry_type      head_entry,
   output queue_status_type    q_status
);

   cell_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign q_status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_entry     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule : acp_queue

`default_nettype wire

@@ hw/rtl/acp_back.sv @@
// Back end: row gap flag memory, column accumulators and the result register.
`default_nettype none

module acp_back
   import acp_pkg::*;
#(
   parameter int MAX_ROWS = DEFAULT_MAX_ROWS
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cell_entry_type  head_entry,
   input  wire queue_status_type q_status,
   output logic                 pop,
   output back_status_type      back_status,
   output logic                 result_valid,
   input  wire logic            result_ready,
   output profile_type          result
);

   localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ROWS - 1);

   logic                gap_mem [MAX_ROWS];

   logic [ADDR_W-1:0]   clear_cnt_ff;
   logic                clear_done_ff;

   logic                stage_valid_ff;
   cell_entry_type      stage_ff;
   logic                rd_flag_ff;

   logic                byp_valid_ff, byp_valid_in;
   logic [ADDR_W-1:0]   byp_addr_ff;
   logic                byp_flag_ff;

   logic [WEIGHT_W-1:0] sum_a_ff, sum_a_in;
   logic [WEIGHT_W-1:0] sum_g_ff, sum_g_in;
   logic [WEIGHT_W-1:0] sum_c_ff, sum_c_in;
   logic [WEIGHT_W-1:0] sum_t_ff, sum_t_in;
   logic [COUNT_W-1:0]  open_ff, open_in;
   logic [COUNT_W-1:0]  extend_ff, extend_in;

   logic                out_valid_ff;
   profile_type         out_ff;

   logic                advance;
   logic                fire;
   logic [ADDR_W-1:0]   stage_addr;
   logic                row_flag;
   logic                gap_flag;
   logic                exec_we;
   logic                exec_flag;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_data;

   // the back end moves cells only after the gap flag sweep and when the result register can take a result
   assign advance = clear_done_ff && (!out_valid_ff || result_ready);
   assign pop     = advance && !q_status.empty;
   assign fire    = advance && stage_valid_ff;

   assign stage_addr = ADDR_W'(stage_ff.row);
   // forward the flag written by the previous cell: the read missed that write
   assign row_flag   = (byp_valid_ff && byp_addr_ff == stage_addr) ? byp_flag_ff : rd_flag_ff;
   assign gap_flag   = stage_ff.first || row_flag;

   assign exec_we   = (stage_ff.kind != KIND_SKIP) || stage_ff.first;
   assign exec_flag = (stage_ff.kind != KIND_BASE);

   always_comb begin
      sum_a_in  = sum_a_ff;
      sum_g_in  = sum_g_ff;
      sum_c_in  = sum_c_ff;
      sum_t_in  = sum_t_ff;
      open_in   = open_ff;
      extend_in = extend_ff;
      unique case (stage_ff.kind)
         KIND_BASE: begin
            if (stage_ff.mask[0]) sum_a_in = sat_add_sum(sum_a_ff, stage_ff.pts);
            if (stage_ff.mask[1]) sum_g_in = sat_add_sum(sum_g_ff, stage_ff.pts);
            if (stage_ff.mask[2]) sum_c_in = sat_add_sum(sum_c_ff, stage_ff.pts);
            if (stage_ff.mask[3]) sum_t_in = sat_add_sum(sum_t_ff, stage_ff.pts);
         end
         KIND_GAP: begin
            if (gap_flag) begin
               if (extend_ff != '1) extend_in = extend_ff + 1'b1;
            end else begin
               if (open_ff != '1) open_in = open_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign byp_valid_in = stage_valid_ff && exec_we;

   always_comb begin
      if (!clear_done_ff) begin
         mem_we   = 1'b1;
         mem_addr = clear_cnt_ff;
         mem_data = 1'b1;
      end else begin
         mem_we   = fire && exec_we;
         mem_addr = stage_addr;
         mem_data = exec_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         gap_mem[mem_addr] <= mem_data;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_flag_ff  <= gap_mem[ADDR_W'(head_entry.row)];
         stage_ff    <= head_entry;
         byp_addr_ff <= stage_addr;
         byp_flag_ff <= exec_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff   <= '0;
         clear_done_ff  <= 1'b0;
         stage_valid_ff <= 1'b0;
         byp_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
         sum_a_ff       <= '0;
         sum_g_ff       <= '0;
         sum_c_ff       <= '0;
         sum_t_ff       <= '0;
         open_ff        <= '0;
         extend_ff      <= '0;
      end else begin
         if (!clear_done_ff) begin
            if (clear_cnt_ff == LAST_ADDR) begin
               clear_done_ff <= 1'b1;
            end else begin
               clear_cnt_ff <= clear_cnt_ff + 1'b1;
            end
         end
         if (advance) begin
            stage_valid_ff <= !q_status.empty;
            byp_valid_ff   <= byp_valid_in;
         end
         if (fire && stage_ff.last) begin
            out_valid_ff <= 1'b1;
         end else if (result_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (fire) begin
            if (stage_ff.last) begin
               sum_a_ff  <= '0;
               sum_g_ff  <= '0;
               sum_c_ff  <= '0;
               sum_t_ff  <= '0;
               open_ff   <= '0;
               extend_ff <= '0;
            end else begin
               sum_a_ff  <= sum_a_in;
               sum_g_ff  <= sum_g_in;
               sum_c_ff  <= sum_c_in;
               sum_t_ff  <= sum_t_in;
               open_ff   <= open_in;
               extend_ff <= extend_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && stage_ff.last) begin
         out_ff.column       <= stage_ff.column;
         out_ff.sum_a        <= sum_a_in;
         out_ff.sum_g        <= sum_g_in;
         out_ff.sum_c        <= sum_c_in;
         out_ff.sum_t        <= sum_t_in;
         out_ff.open_count   <= open_in;
         out_ff.extend_count <= extend_in;
      end
   end

   assign result_valid            = out_valid_ff;
   assign result                  = out_ff;
   assign back_status.clear_done  = clear_done_ff;
   assign back_status.stage_valid = stage_valid_ff;
   assign back_status.stage_last  = stage_ff.last;

endmodule : acp_back

`default_nettype wire

@@ hw/rtl/alignment_column_profile.sv @@
// Alignment column profile: one request per row cell, one response per finished column.
//
// Request channel (req_*): one cell per request. tdata carries row, column and
// nucleotide mask; tuser carries the present and first-column flags; tlast marks
// the final row's cell of a column. Rows outside MAX_ROWS fold back modulo MAX_ROWS.
// Response channel (rsp_*): one profile per column, sent after its last cell:
// column index, four nucleotide weights and the gap-open / gap-extend weights.
// Throughput: one request per cycle after the sweep and while no response is held.
// The per-row gap flag is a one-bit memory read as a cell enters the stage, ahead of
// its update, with the previous write forwarded, so the read-modify-write loop closes
// every cycle. Path: the cell with tlast passes a queue slot, then the stage with the
// flag read, then the result register, where its response turns valid.
// Reset: all accumulators clear and the gap flag memory is swept to ones, one row
// per cycle, over all MAX_ROWS rows; req_tready stays low during the sweep.
// Stall: while rsp_tready is low with a response waiting, the back end holds; the
// four-entry queue keeps accepting requests until it fills, then req_tready drops.
`default_nettype none

module alignment_column_profile
   import acp_pkg::*;
#(
   parameter int MAX_ROWS    = DEFAULT_MAX_ROWS,
   parameter int COLUMN_BITS = DEFAULT_COLUMN_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [9:0] row_index, [25:10] column_index, [29:26] base_mask, [31:30] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] base_present, [1] first_column
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   // last_in_column
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [15:0] profile_column, [29:16] weight_a, [43:30] weight_g, [57:44] weight_c,
   // [71:58] weight_t, [85:72] gap_open_weight, [99:86] gap_extend_weight,
   // [103:100] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   queue_status_type q_status;
   back_status_type  back_status;
   logic             push_valid;
   cell_entry_type   push_entry;
   cell_entry_type   head_entry;
   logic             pop;
   profile_type      result;

   acp_front #(
      .MAX_ROWS    (MAX_ROWS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .q_status    (q_status),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   acp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   acp_back #(
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .q_status     (q_status),
      .pop          (pop),
      .back_status  (back_status),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = RSP_TDATA_W'({gap_weight(result.extend_count),
                                    gap_weight(result.open_count),
                                    result.sum_t,
                                    result.sum_c,
                                    result.sum_g,
                                    result.sum_a,
                                    result.column});

`ifndef SYNTHESIS
   // no request may enter while the gap flags are still being swept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> back_status.clear_done)
      else $error("request accepted during gap flag sweep");

   assert property (@(posedge clock) disable iff (reset)
      !back_status.clear_done |-> !back_status.stage_valid)
      else $error("back end holds a cell during gap flag sweep");

   // a new response only follows a column's last cell in the back end
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_status.stage_valid && back_status.stage_last))
      else $error("response without a last cell");

   assert property (@(posedge clock) disable iff (reset)
      !q_status.empty |-> back_status.clear_done)
      else $error("queue filled during gap flag sweep");
`endif

endmodule : alignment_column_profile

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking stream testbench for the alignment column profile block.
`timescale 1ns / 100ps

module testbench
   import acp_pkg::*;
();

   localparam int ROW_COUNT   = 1 << ROW_FIELD_W;
   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0]    row;
      logic [COLUMN_FIELD_W-1:0] column;
      logic                      present;
      logic [MASK_W-1:0]         mask;
      logic                      first;
      logic                      last;
   } cell_req_type;

   typedef struct packed {
      logic [COLUMN_FIELD_W-1:0] column;
      logic [WEIGHT_W-1:0]       weight_a;
      logic [WEIGHT_W-1:0]       weight_g;
      logic [WEIGHT_W-1:0]       weight_c;
      logic [WEIGHT_W-1:0]       weight_t;
      logic [WEIGHT_W-1:0]       gap_open;
      logic [WEIGHT_W-1:0]       gap_extend;
   } column_profile_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // [9:0] row_index, [25:10] column_index, [29:26] base_mask, [31:30] zero
   logic [REQ_TDATA_W-1:0] req_tdata;
   // [0] base_present, [1] first_column
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // [15:0] profile_column, [29:16] weight_a, [43:30] weight_g, [57:44] weight_c,
   // [71:58] weight_t, [85:72] gap_open_weight, [99:86] gap_extend_weight
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // profile model state
   bit gap_flag [0:ROW_COUNT-1];
   int acc_a, acc_g, acc_c, acc_t;
   int open_n, extend_n;

   column_profile_type pending_profiles [$];
   int  mismatch_count   = 0;
   int  requests_sent    = 0;
   int  profiles_checked = 0;
   int  cycle_count      = 0;
   int  hold_cycles      = 0;
   bit  steady           = 0;

   alignment_column_profile dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // mostly idle-free, some short gaps, a few long ones
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d, %s: got %0d, expected %0d",
                  cycle_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic int sat(input int value, input int limit);
      return (value > limit) ? limit : value;
   endfunction

   task automatic clear_profile_sums();
      acc_a = 0; acc_g = 0; acc_c = 0; acc_t = 0;
      open_n = 0; extend_n = 0;
   endtask

   task automatic predict_profile(input cell_req_type c, output bit emit,
                                  output column_profile_type p);
      int pts;
      int sum_max;
      sum_max = int'(SUM_MAX);
      if (c.first)
         gap_flag[c.row] = 1'b1;
      if (c.present) begin
         if (c.mask != 0) begin
            pts = UNIT_WEIGHT / $countones(c.mask);
            if (c.mask[0]) acc_a = sat(acc_a + pts, sum_max);
            if (c.mask[1]) acc_g = sat(acc_g + pts, sum_max);
            if (c.mask[2]) acc_c = sat(acc_c + pts, sum_max);
            if (c.mask[3]) acc_t = sat(acc_t + pts, sum_max);
            gap_flag[c.row] = 1'b0;
         end
      end else if (gap_flag[c.row]) begin
         extend_n = sat(extend_n + 1, COUNT_MAX);
      end else begin
         gap_flag[c.row] = 1'b1;
         open_n = sat(open_n + 1, COUNT_MAX);
      end
      emit = c.last;
      p = '0;
      if (c.last) begin
         p.column     = c.column;
         p.weight_a   = acc_a[WEIGHT_W-1:0];
         p.weight_g   = acc_g[WEIGHT_W-1:0];
         p.weight_c   = acc_c[WEIGHT_W-1:0];
         p.weight_t   = acc_t[WEIGHT_W-1:0];
         p.gap_open   = WEIGHT_W'(sat(open_n * UNIT_WEIGHT, sum_max));
         p.gap_extend = WEIGHT_W'(sat(extend_n * UNIT_WEIGHT, sum_max));
         clear_profile_sums();
      end
   endtask

   function automatic cell_req_type make_cell(input int row, input int column,
                                              input bit present, input int mask,
                                              input bit first, input bit last);
      cell_req_type c;
      c.row     = ROW_FIELD_W'(row);
      c.column  = COLUMN_FIELD_W'(column);
      c.present = present;
      c.mask    = MASK_W'(mask);
      c.first   = first;
      c.last    = last;
      return c;
   endfunction

   task automatic send_cell(input cell_req_type c);
      int gap;
      bit emit;
      column_profile_type p;
      gap = steady ? 0 : pick_idle();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({c.mask, c.column, c.row});
      req_tuser  <= {c.first, c.present};
      req_tlast  <= c.last;
      do @(posedge clock); while (!req_tready);
      predict_profile(c, emit, p);
      if (emit)
         pending_profiles.insert(pending_profiles.size(), p);
      requests_sent++;
   endtask

   task automatic release_request();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // receiver: random stalls, plus a long hold-off when asked
   initial begin : response_ready
      int stall_left;
      int n;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready  <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            n = pick_idle();
            rsp_tready <= (n == 0);
            stall_left = (n > 0) ? n - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin : response_check
      column_profile_type got;
      column_profile_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.column     = rsp_tdata[15:0];
         got.weight_a   = rsp_tdata[29:16];
         got.weight_g   = rsp_tdata[43:30];
         got.weight_c   = rsp_tdata[57:44];
         got.weight_t   = rsp_tdata[71:58];
         got.gap_open   = rsp_tdata[85:72];
         got.gap_extend = rsp_tdata[99:86];
         if (pending_profiles.size() == 0) begin
            report_mismatch("profile with nothing pending, column", got.column, 0);
         end else begin
            want = pending_profiles.pop_front();
            if (got.column != want.column)
               report_mismatch("profile_column", got.column, want.column);
            if (got.weight_a != want.weight_a)
               report_mismatch("weight_a", got.weight_a, want.weight_a);
            if (got.weight_g != want.weight_g)
               report_mismatch("weight_g", got.weight_g, want.weight_g);
            if (got.weight_c != want.weight_c)
               report_mismatch("weight_c", got.weight_c, want.weight_c);
            if (got.weight_t != want.weight_t)
               report_mismatch("weight_t", got.weight_t, want.weight_t);
            if (got.gap_open != want.gap_open)
               report_mismatch("gap_open_weight", got.gap_open, want.gap_open);
            if (got.gap_extend != want.gap_extend)
               report_mismatch("gap_extend_weight", got.gap_extend, want.gap_extend);
            profiles_checked++;
         end
      end
   end

   // extremes of every field, all sixteen masks, empty mask, first-column override
   task automatic directed_test();
      steady = 1'b0;
      send_cell(make_cell(0,    0, 1, 4'h1, 1, 0));
      send_cell(make_cell(1023, 0, 1, 4'h2, 1, 0));
      send_cell(make_cell(5,    0, 1, 4'h4, 1, 0));
      send_cell(make_cell(6,    0, 1, 4'h8, 1, 0));
      send_cell(make_cell(7,    0, 0, 4'h0, 1, 0));
      send_cell(make_cell(8,    0, 1, 4'h0, 1, 1));
      // row 0 leaves a base and opens; rows 7 and 8 stay in their gap
      send_cell(make_cell(0,    1, 0, 4'hF, 0, 0));
      send_cell(make_cell(7,    1, 0, 4'h0, 0, 0));
      send_cell(make_cell(8,    1, 0, 4'h0, 0, 0));
      send_cell(make_cell(1023, 1, 1, 4'hF, 0, 0));
      send_cell(make_cell(5,    1, 1, 4'h3, 0, 1));
      send_cell(make_cell(100,  16'hFFFF, 1, 4'h5, 0, 0));
      send_cell(make_cell(200,  16'hFFFF, 1, 4'h6, 0, 0));
      send_cell(make_cell(300,  16'hFFFF, 1, 4'h7, 0, 0));
      send_cell(make_cell(400,  16'hFFFF, 1, 4'h9, 0, 0));
      send_cell(make_cell(500,  16'hFFFF, 1, 4'hA, 0, 0));
      send_cell(make_cell(600,  16'hFFFF, 1, 4'hB, 0, 0));
      send_cell(make_cell(700,  16'hFFFF, 1, 4'hC, 0, 0));
      send_cell(make_cell(800,  16'hFFFF, 1, 4'hD, 0, 0));
      send_cell(make_cell(900,  16'hFFFF, 1, 4'hE, 0, 1));
      send_cell(make_cell(0,    16'h8000, 0, 4'h0, 0, 1));
      // row 1023 is out of a gap, but the first-column flag forces an extend
      send_cell(make_cell(1023, 16'h8001, 0, 4'h0, 1, 1));
      release_request();
   endtask

   // one oversized column over a few rows: the A weight runs into its ceiling,
   // with a sparse gap cell now and then
   task automatic saturation_test();
      int row;
      int column;
      bit present;
      steady = 1'b0;
      column = $urandom_range(0, 65535);
      for (int g = 0; g < 1390; g++) begin
         row     = $urandom_range(0, 7);
         present = (g % 100 != 50);
         send_cell(make_cell(row, column, present, present ? 1 : 0, 0, g == 1389));
      end
      release_request();
   endtask

   // hold the response side off while requests keep coming
   task automatic backpressure_test();
      steady = 1'b1;
      hold_cycles = 300;
      for (int i = 0; i < 40; i++)
         send_cell(make_cell($urandom_range(0, ROW_COUNT - 1), $urandom_range(0, 65535),
                             1'($urandom_range(0, 1)), $urandom_range(0, 15), 0, 1));
      release_request();
      steady = 1'b0;
   endtask

   // alignment blocks of random shape, mixed with loose cells
   task automatic random_test(input int target);
      int start;
      int n_rows;
      int n_cols;
      int base;
      int stride;
      int column;
      int n;
      cell_req_type c;
      start = requests_sent;
      while (requests_sent - start < target) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 85) begin
            n_rows = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8);
            n_cols = $urandom_range(2, 6);
            base   = $urandom_range(0, ROW_COUNT - 1);
            stride = 2 * $urandom_range(0, ROW_COUNT / 2 - 1) + 1;
            column = $urandom_range(0, 65535);
            for (int k = 0; k < n_cols; k++) begin
               for (int r = 0; r < n_rows; r++) begin
                  c.row     = ROW_FIELD_W'((base + r * stride) % ROW_COUNT);
                  c.column  = COLUMN_FIELD_W'(column);
                  c.present = ($urandom_range(0, 99) < 65);
                  c.mask    = MASK_W'(($urandom_range(0, 9) == 0) ? 0
                                                                  : $urandom_range(1, 15));
                  c.first   = (k == 0);
                  c.last    = (r == n_rows - 1);
                  send_cell(c);
               end
               column = (column + 1) % 65536;
            end
         end else begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
               c.row     = ROW_FIELD_W'($urandom_range(0, ROW_COUNT - 1));
               c.column  = COLUMN_FIELD_W'($urandom_range(0, 65535));
               c.present = 1'($urandom_range(0, 1));
               c.mask    = MASK_W'($urandom_range(0, 15));
               c.first   = 1'($urandom_range(0, 1));
               c.last    = ($urandom_range(0, 3) == 0);
               send_cell(c);
            end
         end
      end
      release_request();
      steady = 1'b0;
   endtask

   initial begin : main_sequence
      int drain;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tlast  = 1'b0;
      for (int r = 0; r < ROW_COUNT; r++)
         gap_flag[r] = 1'b1;
      clear_profile_sums();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      directed_test();
      saturation_test();
      backpressure_test();
      random_test(100);

      drain = 0;
      while (pending_profiles.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (pending_profiles.size() != 0)
         report_mismatch("profiles never delivered", pending_profiles.size(), 0);

      $display("sent %0d cells (directed, saturating column, back-pressure, random blocks)",
               requests_sent);
      $display("compared %0d column profiles field by field", profiles_checked);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/acp_pkg.sv
hw/rtl/acp_front.sv
hw/rtl/acp_queue.sv
hw/rtl/acp_back.sv
hw/rtl/alignment_column_profile.sv
bench/testbench.sv
